FILE: rtl/pulse_flow_meter_top_defines.svh
// assertion macros for the pulse flow meter
// used by pulse_flow_meter_top, expects clk and arst_n in scope
`ifndef PULSE_FLOW_METER_TOP_DEFINES_SVH
`define PULSE_FLOW_METER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PFM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define PFM_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PFM_ASSERT_IMP(label, ante, cons)
`define PFM_ASSERT_NXT(label, ante, cons)
`endif
`endif

FILE: rtl/pfm_pkg.sv
// types and constants for the pulse flow meter
// no dependencies
`timescale 1ns / 1ps
package pfm_pkg;
	localparam logic [1:0] FUNC_PULSE     = 2'd0;
	localparam logic [1:0] FUNC_TICK      = 2'd1;
	localparam logic [1:0] FUNC_RST_DAILY = 2'd2;
	localparam logic [1:0] FUNC_RST_INT   = 2'd3;

	localparam logic [0:0] REG_VPP     = 1'b0;
	localparam logic [0:0] REG_DENSITY = 1'b1;

	localparam int MS_PER_MIN  = 60000;
	localparam int MIN_PER_DAY = 1440;
	localparam logic [29:0] NANO       = 30'd1000000000;
	// floor(2^61 / 1e9), used on bits [50:21] of a 51-bit dividend
	localparam logic [31:0] RECIP_NANO = 32'd2305843009;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [31:0] pulse_count;
		logic [31:0] daily_pulse_count;
		logic [47:0] total_volume_ul;
		logic [47:0] daily_volume_ul;
		logic [31:0] last_interval_ms;
		logic [39:0] flow_ul_per_min;
		logic [50:0] flow_ul_per_day;
		logic [51:0] mass_g_per_day;
		logic        flow_active;
	} out_item_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic decide;
		logic div_step;
		logic flow_set;
		logic per_day;
		logic m_est;
		logic m_rem;
		logic m_fix;
		logic x_from_rem;
		logic mass_set;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic do_div;
	} stat_t;
endpackage

FILE: rtl/pfm_dp.sv
// datapath: counters, interval ring, running sum, flow divider, mass scaling, result register
// depends on pfm_pkg
`timescale 1ns / 1ps
module pfm_dp #(
	parameter int WINDOW = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pfm_pkg::in_item_t in_item,
	input  logic [23:0]       vpp,
	input  logic [20:0]       density,
	input  pfm_pkg::cmd_t     cmd,
	output pfm_pkg::stat_t    stat,
	output pfm_pkg::out_item_t out_item
);
	localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FW = $clog2(WINDOW + 1);
	localparam int SW = 32 + FW;
	localparam int NW = 40 + FW;
	localparam int RW = SW + 1;

	logic [1:0]  func_q;
	logic [31:0] now_q;
	logic [31:0] ring_mem [WINDOW];
	logic [31:0] old_q;
	logic [IW-1:0] idx_q;
	logic [FW-1:0] fill_q;
	logic [SW-1:0] sum_q;
	logic [31:0] last_q;
	logic        have_q;
	logic [31:0] latest_q;
	logic [31:0] pulses_q, daily_q;
	logic [47:0] vol_q, vol_daily_q;
	logic [39:0] flow_q;
	logic [31:0] gap_q;
	logic [39:0] vpp60k_q;
	logic [RW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [SW-1:0] den_q;
	logic [50:0] per_day_q;
	logic [50:0] x_q;
	logic [21:0] est_q;
	logic [30:0] rm_q;
	logic [21:0] q_q;
	logic [29:0] r_q;
	logic [21:0] q1_q;
	logic [51:0] mass_q;
	pfm_pkg::out_item_t res_q;

	logic [31:0] iv;
	logic        ring_wr;
	logic        avg_ok;
	logic [47:0] gap_x_fill, three_sum;
	logic        tick_zero, tick_div;
	logic [NW-1:0] num;
	logic [RW-1:0] trial;
	logic        fits;
	logic [50:0] per_day_d;
	logic [61:0] est_prod;
	logic [51:0] m_prod;
	logic [50:0] m_diff;

	assign iv      = now_q - last_q;
	assign ring_wr = cmd.exec && (func_q == pfm_pkg::FUNC_PULSE) && have_q && (iv != 32'd0);
	assign avg_ok  = (fill_q != '0) && (sum_q >= SW'(fill_q));
	assign gap_x_fill = 48'(gap_q * fill_q);
	assign three_sum  = 48'(sum_q) + 48'({sum_q, 1'b0});
	assign tick_zero  = (fill_q == '0) || !have_q || (avg_ok && (gap_x_fill > three_sum));
	assign tick_div   = !tick_zero && avg_ok;
	assign num        = NW'(vpp60k_q * fill_q);
	assign trial      = {rem_q[RW-2:0], quo_q[NW-1]};
	assign fits       = trial >= RW'(den_q);

	// divide by 1e9: reciprocal estimate is low by at most one, one correction step
	assign per_day_d = 51'(flow_q * 11'(pfm_pkg::MIN_PER_DAY));
	assign est_prod  = 62'(x_q[50:21] * pfm_pkg::RECIP_NANO);
	assign m_prod    = 52'(est_q * pfm_pkg::NANO);
	assign m_diff    = x_q - m_prod[50:0];

	always_comb begin
		case (func_q)
			pfm_pkg::FUNC_PULSE: stat.do_div = avg_ok;
			pfm_pkg::FUNC_TICK:  stat.do_div = tick_div;
			default:             stat.do_div = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ring_wr) begin
			ring_mem[idx_q] <= iv;
		end
		old_q <= ring_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			fill_q <= '0;
			sum_q <= '0;
			last_q <= '0;
			have_q <= 1'b0;
			latest_q <= '0;
			pulses_q <= '0;
			daily_q <= '0;
			vol_q <= '0;
			vol_daily_q <= '0;
			flow_q <= '0;
		end else begin
			if (cmd.exec) begin
				unique case (func_q)
					pfm_pkg::FUNC_PULSE: begin
						pulses_q <= pulses_q + 32'd1;
						daily_q <= daily_q + 32'd1;
						vol_q <= vol_q + 48'(vpp);
						vol_daily_q <= vol_daily_q + 48'(vpp);
						if (ring_wr) begin
							latest_q <= iv;
							sum_q <= sum_q + SW'(iv)
								- ((fill_q == FW'(WINDOW)) ? SW'(old_q) : SW'(0));
							idx_q <= (idx_q == IW'(WINDOW - 1)) ? '0 : idx_q + IW'(1);
							if (fill_q < FW'(WINDOW)) begin
								fill_q <= fill_q + FW'(1);
							end
						end
						last_q <= now_q;
						have_q <= 1'b1;
					end
					pfm_pkg::FUNC_TICK: begin
					end
					pfm_pkg::FUNC_RST_DAILY: begin
						daily_q <= '0;
						vol_daily_q <= '0;
					end
					pfm_pkg::FUNC_RST_INT: begin
						idx_q <= '0;
						fill_q <= '0;
						sum_q <= '0;
						last_q <= '0;
						have_q <= 1'b0;
						latest_q <= '0;
						flow_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.decide && (func_q == pfm_pkg::FUNC_TICK) && tick_zero) begin
				flow_q <= '0;
			end
			if (cmd.flow_set) begin
				flow_q <= quo_q[39:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= in_item.func;
			now_q <= in_item.now_ms;
		end
		if (cmd.exec) begin
			gap_q <= now_q - last_q;
			vpp60k_q <= 40'(vpp * 16'(pfm_pkg::MS_PER_MIN));
		end
		if (cmd.decide) begin
			rem_q <= '0;
			den_q <= sum_q;
			quo_q <= num;
		end else if (cmd.div_step) begin
			rem_q <= fits ? trial - RW'(den_q) : trial;
			quo_q <= {quo_q[NW-2:0], fits};
		end
		if (cmd.per_day) begin
			per_day_q <= per_day_d;
			x_q <= per_day_d;
		end else if (cmd.x_from_rem) begin
			x_q <= 51'(r_q * density);
			q1_q <= q_q;
		end
		if (cmd.m_est) begin
			est_q <= est_prod[61:40];
		end
		if (cmd.m_rem) begin
			rm_q <= m_diff[30:0];
		end
		if (cmd.m_fix) begin
			if (rm_q >= 31'(pfm_pkg::NANO)) begin
				q_q <= est_q + 22'd1;
				r_q <= 30'(rm_q - 31'(pfm_pkg::NANO));
			end else begin
				q_q <= est_q;
				r_q <= rm_q[29:0];
			end
		end
		if (cmd.mass_set) begin
			mass_q <= 52'(q1_q * density) + 52'(q_q);
		end
		if (cmd.out_load) begin
			res_q.pulse_count <= pulses_q;
			res_q.daily_pulse_count <= daily_q;
			res_q.total_volume_ul <= vol_q;
			res_q.daily_volume_ul <= vol_daily_q;
			res_q.last_interval_ms <= latest_q;
			res_q.flow_ul_per_min <= flow_q;
			res_q.flow_ul_per_day <= per_day_q;
			res_q.mass_g_per_day <= mass_q;
			res_q.flow_active <= flow_q != '0;
		end
	end

	assign out_item = res_q;
endmodule

FILE: rtl/pfm_ctrl.sv
// controller: sequences one item through update, an optional flow divide and mass steps
// depends on pfm_pkg
`timescale 1ns / 1ps
module pfm_ctrl #(
	parameter int WINDOW = 10
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  pfm_pkg::stat_t stat,
	output pfm_pkg::cmd_t  cmd
);
	localparam int FLOW_STEPS = 40 + $clog2(WINDOW + 1);

	typedef enum logic [11:0] {
		S_IDLE = 12'b000000000001,
		S_EXEC = 12'b000000000010,
		S_DEC  = 12'b000000000100,
		S_FDIV = 12'b000000001000,
		S_FSET = 12'b000000010000,
		S_PDAY = 12'b000000100000,
		S_EST  = 12'b000001000000,
		S_REM  = 12'b000010000000,
		S_FIX  = 12'b000100000000,
		S_XRM  = 12'b001000000000,
		S_MSET = 12'b010000000000,
		S_OUT  = 12'b100000000000
	} state_t;

	state_t state_q, state_d;
	logic [6:0] cnt_q;
	logic       pass_q;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d = S_DEC;
			end
			S_DEC: begin
				cmd.decide = 1'b1;
				state_d = stat.do_div ? S_FDIV : S_PDAY;
			end
			S_FDIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == 7'd0) state_d = S_FSET;
			end
			S_FSET: begin
				cmd.flow_set = 1'b1;
				state_d = S_PDAY;
			end
			S_PDAY: begin
				cmd.per_day = 1'b1;
				state_d = S_EST;
			end
			S_EST: begin
				cmd.m_est = 1'b1;
				state_d = S_REM;
			end
			S_REM: begin
				cmd.m_rem = 1'b1;
				state_d = S_FIX;
			end
			S_FIX: begin
				cmd.m_fix = 1'b1;
				state_d = pass_q ? S_MSET : S_XRM;
			end
			S_XRM: begin
				cmd.x_from_rem = 1'b1;
				state_d = S_EST;
			end
			S_MSET: begin
				cmd.mass_set = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				cmd.out_load = out_free;
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			pass_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.decide) begin
				cnt_q <= 7'(FLOW_STEPS - 1);
			end else if (cmd.div_step && cnt_q != 7'd0) begin
				cnt_q <= cnt_q - 7'd1;
			end
			if (cmd.per_day) begin
				pass_q <= 1'b0;
			end else if (cmd.x_from_rem) begin
				pass_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

FILE: rtl/pulse_flow_meter_top.sv
// Pulse flow meter top: one result item per input item. When a pulse or tick
// recomputes the flow, the block also runs the flow divide before the mass
// steps; otherwise it skips it. The result appears in the same cycle that the
// block frees up. The flow estimate comes from a restoring divider that
// retires one quotient bit a cycle; the daily mass is divided by 1e9 with
// two reciprocal-multiply passes, each an estimate, remainder and correction
// step. A new item is taken once the previous one has moved to the output
// register, and a held output adds its stall cycles.
// depends on pfm_pkg, pfm_ctrl, pfm_dp, pulse_flow_meter_top_defines.svh
`timescale 1ns / 1ps
`include "pulse_flow_meter_top_defines.svh"
module pulse_flow_meter_top #(
	parameter int WINDOW = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  pfm_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output pfm_pkg::out_item_t out_item,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	logic [23:0] vpp_q;
	logic [20:0] density_q;
	pfm_pkg::cmd_t  cmd;
	pfm_pkg::stat_t stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vpp_q <= 24'd1000;
			density_q <= 21'd850000;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				pfm_pkg::REG_VPP:     vpp_q <= pwdata[23:0];
				pfm_pkg::REG_DENSITY: density_q <= pwdata[20:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			pfm_pkg::REG_VPP:     prdata = {8'd0, vpp_q};
			pfm_pkg::REG_DENSITY: prdata = {11'd0, density_q};
			default:              prdata = '0;
		endcase
	end

	pfm_ctrl #(.WINDOW(WINDOW)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
	);

	pfm_dp #(.WINDOW(WINDOW)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .vpp(vpp_q),
		.density(density_q), .cmd(cmd), .stat(stat), .out_item(out_item)
	);

	`PFM_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`PFM_ASSERT_IMP(a_active_flag, out_valid, out_item.flow_active == (out_item.flow_ul_per_min != 40'd0))
	`PFM_ASSERT_IMP(a_no_load_while_held, cmd.out_load, !out_valid || !out_stall)
endmodule
